// ===== rtl/fids_pkg.sv =====
// fids_pkg: widths, register indexes, reset values and arithmetic constants
// for the flux interval data separator. No dependencies.
`timescale 1ns / 1ps

package fids_pkg;

  // payload widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned ZCOUNT_W   = 18;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned PHASE_W    = 16;
  localparam int unsigned OVF_W      = 8;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned TICK_W     = 8;
  localparam int unsigned LIMIT_W    = 8;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEV     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LIMIT  = 3'd5;

  // register reset values
  localparam logic [PERIOD_W-1:0] NOMINAL_RST     = 16'd2000;
  localparam logic [PCT_W-1:0]    PERIOD_GAIN_RST = 7'd5;
  localparam logic [PCT_W-1:0]    PHASE_GAIN_RST  = 7'd60;
  localparam logic [PCT_W-1:0]    MAX_DEV_RST     = 7'd10;
  localparam logic [TICK_W-1:0]   TICK_RST        = 8'd25;
  localparam logic [LIMIT_W-1:0]  SYNC_LIMIT_RST  = 8'd3;

  localparam logic [OVF_W-1:0]    OVERFLOW_LIMIT  = 8'd255;

  // percent handling
  localparam logic [PCT_W-1:0]    GAIN_MAX        = 7'd100;
  localparam logic [PCT_W-1:0]    DEV_MAX         = 7'd99;
  localparam logic [PCT_W:0]      PCT_FULL        = 8'd100;

  // shared multiplier and divide-by-100 reciprocal, exact for operands below 2^24
  localparam int unsigned MUL_W       = 25;
  localparam int unsigned PROD_W      = 2 * MUL_W;
  localparam int unsigned RECIP_SHIFT = 31;
  localparam logic [MUL_W-1:0] RECIP_100 = 25'd21474837;
  localparam int unsigned QUOT_W      = 18;

  // flux interval divider
  localparam int unsigned DIVIDEND_W = 33;
  localparam int unsigned CNT_W      = 6;
  localparam logic [CNT_W-1:0] DIV_STEPS = 6'd33;

  localparam logic [ZCOUNT_W-1:0] ZCOUNT_MAX = 18'h3FFFF;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'hFFFF;

endpackage

// ===== rtl/fids_if.sv =====
// fids_in_if / fids_out_if: valid-ready channels for flux samples and
// recovered half-bit results. Depends on fids_pkg.
`timescale 1ns / 1ps

interface fids_in_if;
  logic                           valid;
  logic                           ready;
  logic [fids_pkg::SAMPLE_W-1:0]  sample;
  logic                           new_track;

  modport source (output valid, sample, new_track, input ready);
  modport sink   (input valid, sample, new_track, output ready);
endinterface

interface fids_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [fids_pkg::ZCOUNT_W-1:0] zero_count;
  logic        [fids_pkg::PERIOD_W-1:0] period_ns;
  logic signed [fids_pkg::PHASE_W-1:0]  phase_error_ns;

  modport source (output valid, zero_count, period_ns, phase_error_ns, input ready);
  modport sink   (input valid, zero_count, period_ns, phase_error_ns, output ready);
endinterface

// ===== rtl/flux_interval_data_separator.sv =====
// flux_interval_data_separator: digital pll that turns flux intervals into
// mfm half-bit runs. Depends on fids_pkg and the channels in fids_if.
`timescale 1ns / 1ps

// Usage
//   in_i carries one flux interval per request (sample, new_track). A zero
//   sample only counts an overflow; a nonzero one may yield one result.
//   out_o carries one result per one half-bit: zero_count, the period after
//   steering and clamping, and the phase error at the one.
//   The cfg port writes a register whenever cfg_we_i is high; write only
//   while the block is idle.
// Timing
//   in_i.ready is high only in the idle state, so items are taken one at a
//   time. An overflow sample ends in the idle state, a sample that stays under
//   half a period ends after the accumulate step, and one that reaches a one
//   runs the bit-serial divider that counts zero half-bits, then steps through
//   the single shared 25x25 multiplier (gain, divide by 100 as a reciprocal
//   multiply, clamp bounds, phase shrink).
// Reset and stall
//   Reset loads the register defaults, a period of 2000 ns and empty
//   residual and overflow counts. A finished result sits in the output
//   register; the next item is still accepted, and its own result waits in
//   the last step until the output register frees up.

module flux_interval_data_separator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fids_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fids_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  fids_in_if.sink                          in_i,
  fids_out_if.source                       out_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ACC  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_SYNC = 4'd3;
  localparam logic [3:0] S_G1   = 4'd4;
  localparam logic [3:0] S_G2   = 4'd5;
  localparam logic [3:0] S_G3   = 4'd6;
  localparam logic [3:0] S_LO1  = 4'd7;
  localparam logic [3:0] S_LO2  = 4'd8;
  localparam logic [3:0] S_HI1  = 4'd9;
  localparam logic [3:0] S_HI2  = 4'd10;
  localparam logic [3:0] S_PH1  = 4'd11;
  localparam logic [3:0] S_PH2  = 4'd12;

  // configuration registers
  logic [fids_pkg::PERIOD_W-1:0] nom_q;
  logic [fids_pkg::PCT_W-1:0]    pg_q, phg_q, dev_q;
  logic [fids_pkg::TICK_W-1:0]   tick_q;
  logic [fids_pkg::LIMIT_W-1:0]  sync_q;

  // loop state and sequencer
  logic [3:0]                        state_q, state_d;
  logic [fids_pkg::PERIOD_W-1:0]     period_q, period_d;
  logic signed [15:0]                res_q, res_d;
  logic [fids_pkg::OVF_W-1:0]        ovf_q, ovf_d;
  logic [fids_pkg::DIVIDEND_W-1:0]   div_q, div_d;
  logic [fids_pkg::PERIOD_W-1:0]     rem_q, rem_d;
  logic [fids_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [17:0]                x_q, x_d;
  logic signed [15:0]                r_q, r_d;
  logic signed [18:0]                cn_q, cn_d;
  logic [fids_pkg::PERIOD_W-1:0]     lo_q, lo_d;
  logic [fids_pkg::PROD_W-1:0]       mul_q;
  logic                              out_valid_q, out_valid_d;
  logic [fids_pkg::ZCOUNT_W-1:0]     zc_q, zc_d;
  logic [fids_pkg::PERIOD_W-1:0]     oper_q, oper_d;
  logic signed [15:0]                ophase_q, ophase_d;

  // combinational helpers
  logic                              in_acc, out_acc, emit;
  logic [fids_pkg::PERIOD_W-1:0]     nom_eff;
  logic [fids_pkg::PCT_W-1:0]        pg_cap, phg_cap, dev_cap;
  logic [fids_pkg::OVF_W-1:0]        ovf_eff;
  logic [14:0]                       half;
  logic signed [33:0]                acc_sum, acc_off;
  logic                              below;
  logic [16:0]                       trial, trial_sub;
  logic                              fits;
  logic signed [17:0]                r_full, x_full;
  logic                              in_sync;
  logic [16:0]                       x_mag, r_mag;
  logic signed [16:0]                r_ext;
  logic [fids_pkg::QUOT_W-1:0]       quot;
  logic signed [18:0]                quot_s;
  logic [18:0]                       c1;
  logic [fids_pkg::PERIOD_W-1:0]     hi_val;
  logic [fids_pkg::MUL_W-1:0]        mul_a, mul_b;
  logic                              mul_en;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nom_q  <= fids_pkg::NOMINAL_RST;
      pg_q   <= fids_pkg::PERIOD_GAIN_RST;
      phg_q  <= fids_pkg::PHASE_GAIN_RST;
      dev_q  <= fids_pkg::MAX_DEV_RST;
      tick_q <= fids_pkg::TICK_RST;
      sync_q <= fids_pkg::SYNC_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fids_pkg::CFG_NOMINAL:     nom_q  <= cfg_wdata_i;
        fids_pkg::CFG_PERIOD_GAIN: pg_q   <= cfg_wdata_i[fids_pkg::PCT_W-1:0];
        fids_pkg::CFG_PHASE_GAIN:  phg_q  <= cfg_wdata_i[fids_pkg::PCT_W-1:0];
        fids_pkg::CFG_MAX_DEV:     dev_q  <= cfg_wdata_i[fids_pkg::PCT_W-1:0];
        fids_pkg::CFG_TICK:        tick_q <= cfg_wdata_i[fids_pkg::TICK_W-1:0];
        fids_pkg::CFG_SYNC_LIMIT:  sync_q <= cfg_wdata_i[fids_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign nom_eff = (nom_q == '0) ? 16'd1 : nom_q;
  assign pg_cap  = (pg_q  > fids_pkg::GAIN_MAX) ? fids_pkg::GAIN_MAX : pg_q;
  assign phg_cap = (phg_q > fids_pkg::GAIN_MAX) ? fids_pkg::GAIN_MAX : phg_q;
  assign dev_cap = (dev_q > fids_pkg::DEV_MAX)  ? fids_pkg::DEV_MAX  : dev_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && (state_q == S_IDLE);
  assign out_acc    = out_valid_q && out_o.ready;
  assign emit       = (state_q == S_PH2) && (!out_valid_q || out_o.ready);

  assign ovf_eff = in_i.new_track ? '0 : ovf_q;
  assign half    = period_q[15:1];

  // residual plus new interval, compared against half a period
  assign acc_sum = $signed({{18{res_q[15]}}, res_q}) + $signed({2'b00, mul_q[31:0]});
  assign acc_off = acc_sum - $signed({19'd0, half});
  assign below   = acc_sum < $signed({19'd0, half});

  // restoring divide step, one quotient bit a cycle
  assign trial     = {rem_q, div_q[fids_pkg::DIVIDEND_W-1]};
  assign fits      = trial >= {1'b0, period_q};
  assign trial_sub = trial - {1'b0, period_q};

  // residual at the one: remainder + half - period
  assign r_full  = $signed({2'b00, rem_q}) + $signed({3'b000, half})
                 - $signed({2'b00, period_q});
  assign in_sync = (div_q[fids_pkg::DIVIDEND_W-1:8] == '0) && (div_q[7:0] <= sync_q);
  assign x_full  = in_sync ? r_full
                 : ($signed({2'b00, nom_eff}) - $signed({2'b00, period_q}));

  assign x_mag = x_q[17] ? 17'(-x_q) : x_q[16:0];
  assign r_ext = {r_q[15], r_q};
  assign r_mag = r_ext[16] ? 17'(-r_ext) : r_ext;

  assign quot   = mul_q[fids_pkg::RECIP_SHIFT+fids_pkg::QUOT_W-1:fids_pkg::RECIP_SHIFT];
  assign quot_s = $signed({1'b0, quot});

  // clamp: low bound first, then high bound
  assign hi_val = (quot > {2'b00, fids_pkg::PERIOD_MAX}) ? fids_pkg::PERIOD_MAX : quot[15:0];
  assign c1     = (cn_q < $signed({3'b000, lo_q})) ? {3'b000, lo_q} : cn_q;

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = (state_q != S_PH2);
    unique case (state_q)
      S_IDLE: begin
        mul_a = {17'd0, tick_q};
        mul_b = {1'b0, ovf_eff, in_i.sample};
      end
      S_G1: begin
        mul_a = {8'd0, x_mag};
        mul_b = {18'd0, pg_cap};
      end
      S_G2, S_LO1, S_HI1, S_PH1: begin
        mul_a = mul_q[fids_pkg::MUL_W-1:0];
        mul_b = fids_pkg::RECIP_100;
      end
      S_G3: begin
        mul_a = {9'd0, nom_eff};
        mul_b = {17'd0, 8'(fids_pkg::PCT_FULL - {1'b0, dev_cap})};
      end
      S_LO2: begin
        mul_a = {9'd0, nom_eff};
        mul_b = {17'd0, 8'(fids_pkg::PCT_FULL + {1'b0, dev_cap})};
      end
      S_HI2: begin
        mul_a = {8'd0, r_mag};
        mul_b = {17'd0, 8'(fids_pkg::PCT_FULL - {1'b0, phg_cap})};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    period_d    = period_q;
    res_d       = res_q;
    ovf_d       = ovf_q;
    div_d       = div_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    x_d         = x_q;
    r_d         = r_q;
    cn_d        = cn_q;
    lo_d        = lo_q;
    out_valid_d = out_valid_q;
    zc_d        = zc_q;
    oper_d      = oper_q;
    ophase_d    = ophase_q;

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.new_track) begin
            period_d = nom_eff;
            res_d    = '0;
          end
          if (in_i.sample == '0) begin
            ovf_d = (ovf_eff < fids_pkg::OVERFLOW_LIMIT) ? ovf_eff + 8'd1 : ovf_eff;
          end else begin
            ovf_d   = '0;
            state_d = S_ACC;
          end
        end
      end
      S_ACC: begin
        if (below) begin
          res_d   = acc_sum[15:0];
          state_d = S_IDLE;
        end else begin
          div_d   = acc_off[fids_pkg::DIVIDEND_W-1:0];
          rem_d   = '0;
          cnt_d   = fids_pkg::DIV_STEPS;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = fits ? trial_sub[15:0] : trial[15:0];
        div_d = {div_q[fids_pkg::DIVIDEND_W-2:0], fits};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          state_d = S_SYNC;
        end
      end
      S_SYNC: begin
        r_d     = r_full[15:0];
        x_d     = x_full;
        state_d = S_G1;
      end
      S_G1:  state_d = S_G2;
      S_G2:  state_d = S_G3;
      S_G3: begin
        cn_d    = $signed({3'b000, period_q}) + (x_q[17] ? -quot_s : quot_s);
        state_d = S_LO1;
      end
      S_LO1: state_d = S_LO2;
      S_LO2: begin
        lo_d    = (quot == '0) ? 16'd1 : quot[15:0];
        state_d = S_HI1;
      end
      S_HI1: state_d = S_HI2;
      S_HI2: begin
        period_d = (c1 > {3'b000, hi_val}) ? hi_val : c1[15:0];
        state_d  = S_PH1;
      end
      S_PH1: state_d = S_PH2;
      S_PH2: begin
        // hold here until the output register is free
        if (emit) begin
          res_d       = r_q[15] ? 16'(-quot_s) : quot_s[15:0];
          zc_d        = (div_q[fids_pkg::DIVIDEND_W-1:fids_pkg::ZCOUNT_W] != '0)
                      ? fids_pkg::ZCOUNT_MAX : div_q[fids_pkg::ZCOUNT_W-1:0];
          oper_d      = period_q;
          ophase_d    = r_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      period_q    <= fids_pkg::NOMINAL_RST;
      res_q       <= '0;
      ovf_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      period_q    <= period_d;
      res_q       <= res_d;
      ovf_q       <= ovf_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    div_q    <= div_d;
    rem_q    <= rem_d;
    x_q      <= x_d;
    r_q      <= r_d;
    cn_q     <= cn_d;
    lo_q     <= lo_d;
    zc_q     <= zc_d;
    oper_q   <= oper_d;
    ophase_q <= ophase_d;
    if (mul_en) begin
      mul_q <= mul_a * mul_b;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.zero_count     = zc_q;
  assign out_o.period_ns      = oper_q;
  assign out_o.phase_error_ns = ophase_q;

  // an overflow sample never produces a result
  a_ovf_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.sample == '0 && !out_valid_q) |=> !out_valid_q)
    else $error("result raised after an overflow sample");

  // a new result comes only from the last sequencer step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_PH2)
    else $error("result raised outside the final step");

  // the clamped period is never zero
  a_period_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> out_o.period_ns != '0)
    else $error("zero clock period in result");

  // divider step count stays within the dividend width
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q != '0 && cnt_q <= fids_pkg::DIV_STEPS))
    else $error("divider step count out of range");

endmodule
